/* hdl/pfa_pkg.sv */
// ============================================================================
// pfa_pkg: shared types and constants of the page frame allocator
// Sizes of the in-use map, result codes and the control/status bundles
// that pass between the controller and the datapath.
// ============================================================================
package pfa_pkg;

	localparam int MAX_FRAMES      = 4096;
	localparam int RESERVED_FRAMES = 256;
	localparam int FRAME_BYTES     = 4096;

	localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);      // 12
	localparam int CNT_W       = FRAME_IDX_W + 1;         // 13
	localparam int WORD_W      = 32;
	localparam int BIT_W       = $clog2(WORD_W);          // 5
	localparam int MAP_WORDS   = MAX_FRAMES / WORD_W;     // 128
	localparam int ROW_W       = $clog2(MAP_WORDS);       // 7
	localparam int VISIT_W     = ROW_W + 1;
	localparam int OFFS_W      = $clog2(FRAME_BYTES);     // 12
	localparam int ADDR_W      = 32;
	localparam int PIDX_W      = ADDR_W - OFFS_W;         // 20
	localparam int GRANT_W     = 24;
	localparam int STATUS_W    = 3;
	localparam int OUT_W       = 40;

	localparam logic [CNT_W-1:0] N_MIN     = CNT_W'(RESERVED_FRAMES + 1);
	localparam logic [CNT_W-1:0] N_MAX     = CNT_W'(MAX_FRAMES);
	localparam logic [CNT_W-1:0] N_RESET   = CNT_W'(4096);
	localparam logic [CNT_W-1:0] RES_COUNT = CNT_W'(RESERVED_FRAMES);

	localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic accept;
		logic start;
		logic scan;
		logic free_chk;
		logic load_out;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic cmd_free;
		logic alloc_full;
		logic out_range;
		logic found;
		logic miss;
		logic clear_done;
		logic out_free;
	} sts_t;

endpackage

/* hdl/pfa_ctrl.sv */
// ============================================================================
// pfa_ctrl: allocator sequencer
// Steps each request through start, map scan or free check (unless full or out
// of range) and result load, and runs the map clearing pass after reset.
// ============================================================================
module pfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pfa_pkg::sts_t sts,
	output pfa_pkg::ctl_t ctl
);
	import pfa_pkg::*;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_START    = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_FREE_CHK = 3'd4;
	localparam logic [2:0] S_OUT      = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctl          = '0;
		ctl.accept   = (state_q == S_IDLE) && in_valid;
		ctl.start    = (state_q == S_START);
		ctl.scan     = (state_q == S_SCAN);
		ctl.free_chk = (state_q == S_FREE_CHK);
		ctl.load_out = (state_q == S_OUT) && sts.out_free;
		ctl.clear    = (state_q == S_CLEAR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				if (sts.cmd_free) state_d = sts.out_range ? S_OUT : S_FREE_CHK;
				else state_d = sts.alloc_full ? S_OUT : S_SCAN;
			end
			S_SCAN: begin
				if (sts.found || sts.miss) state_d = S_OUT;
			end
			S_FREE_CHK: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

endmodule

/* hdl/pfa_dp.sv */
// ============================================================================
// pfa_dp: allocator datapath
// Holds the in-use map as 32-bit words, the search hint, the used count,
// the frame count register and the output register.
// ============================================================================
module pfa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfa_pkg::ctl_t                  ctl,
	output pfa_pkg::sts_t                  sts,
	input  logic                           in_cmd,
	input  logic [pfa_pkg::ADDR_W-1:0]     in_addr,
	input  logic                           cfg_we,
	input  logic [pfa_pkg::CNT_W-1:0]      cfg_wdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pfa_pkg::OUT_W-1:0]      out_data
);
	import pfa_pkg::*;

	// Registers
	logic [CNT_W-1:0]       frame_count_q;
	logic [FRAME_IDX_W-1:0] hint_q;
	logic [CNT_W-1:0]       used_q;
	logic                   cmd_q;
	logic [PIDX_W-1:0]      pidx_q;
	logic [FRAME_IDX_W-1:0] start_idx_q;
	logic [ROW_W-1:0]       rd_w_q;
	logic [VISIT_W-1:0]     remain_q;
	logic                   first_iss_q;
	logic                   vld_s1;
	logic [ROW_W-1:0]       w_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic [ROW_W-1:0]       clr_q;
	logic [WORD_W-1:0]      rdata_q;
	logic [GRANT_W-1:0]     res_grant_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;

	logic [WORD_W-1:0] map_mem [0:MAP_WORDS-1];

	// Combinational
	logic [CNT_W-1:0]       n_eff;
	logic [CNT_W-1:0]       n_m1;
	logic [ROW_W-1:0]       last_w;
	logic [FRAME_IDX_W-1:0] i0;
	logic [WORD_W-1:0]      mask;
	logic [WORD_W-1:0]      cand;
	logic [BIT_W-1:0]       bitpos;
	logic [FRAME_IDX_W-1:0] hit_idx;
	logic [CNT_W-1:0]       hit_next;
	logic [FRAME_IDX_W-1:0] fidx;
	logic                   fbit;
	logic                   issue;
	logic                   found;
	logic                   miss;
	logic                   mem_we;
	logic [ROW_W-1:0]       mem_waddr;
	logic [WORD_W-1:0]      mem_wdata;
	logic [ROW_W-1:0]       mem_raddr;
	logic [WORD_W-1:0]      clr_word;
	logic [CNT_W-1:0]       free_cnt;
	logic                   out_free;

	always_comb begin
		if (frame_count_q < N_MIN) n_eff = N_MIN;
		else if (frame_count_q > N_MAX) n_eff = N_MAX;
		else n_eff = frame_count_q;
	end

	assign n_m1   = n_eff - CNT_W'(1);
	assign last_w = n_m1[FRAME_IDX_W-1:BIT_W];
	assign i0     = ({1'b0, hint_q} < n_eff) ? hint_q : '0;
	assign fidx   = pidx_q[FRAME_IDX_W-1:0];
	assign fbit   = rdata_q[fidx[BIT_W-1:0]];

	// Each scan visit looks at one word. The first visit keeps bits from the
	// start offset up, the final wrapped visit of the same word keeps the bits
	// below it, and the word holding the last frame drops bits past the count.
	always_comb begin
		mask = '1;
		if (first_s1) mask = mask & ({WORD_W{1'b1}} << start_idx_q[BIT_W-1:0]);
		if (last_s1) mask = mask & ~({WORD_W{1'b1}} << start_idx_q[BIT_W-1:0]);
		if (w_s1 == last_w)
			mask = mask & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - n_m1[BIT_W-1:0]));
	end

	assign cand = ~rdata_q & mask;

	always_comb begin
		bitpos = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (cand[k]) bitpos = BIT_W'(k);
		end
	end

	assign hit_idx  = {w_s1, bitpos};
	assign hit_next = {1'b0, hit_idx} + CNT_W'(1);
	assign found    = ctl.scan && vld_s1 && (cand != '0);
	assign miss     = ctl.scan && vld_s1 && last_s1 && (cand == '0);
	assign issue    = ctl.scan && (remain_q != '0);

	always_comb begin
		logic [FRAME_IDX_W-1:0] fi;
		clr_word = '0;
		for (int k = 0; k < WORD_W; k++) begin
			fi = {clr_q, BIT_W'(k)};
			clr_word[k] = ({1'b0, fi} < RES_COUNT);
		end
	end

	// Memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = clr_word;
		if (ctl.clear) begin
			mem_we = 1'b1;
		end else if (found) begin
			mem_we    = 1'b1;
			mem_waddr = w_s1;
			mem_wdata = rdata_q | (WORD_W'(1) << bitpos);
		end else if (ctl.free_chk && fbit) begin
			mem_we    = 1'b1;
			mem_waddr = fidx[FRAME_IDX_W-1:BIT_W];
			mem_wdata = rdata_q & ~(WORD_W'(1) << fidx[BIT_W-1:0]);
		end
	end

	assign mem_raddr = ctl.start ? fidx[FRAME_IDX_W-1:BIT_W] : rd_w_q;

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[mem_waddr] <= mem_wdata;
		rdata_q <= map_mem[mem_raddr];
	end

	// Request and scan tags
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q  <= in_cmd;
			pidx_q <= in_addr[ADDR_W-1:OFFS_W];
		end
		if (ctl.start) begin
			start_idx_q <= i0;
			rd_w_q      <= i0[FRAME_IDX_W-1:BIT_W];
			remain_q    <= {1'b0, last_w} + VISIT_W'(2);
			first_iss_q <= 1'b1;
		end else if (issue) begin
			rd_w_q      <= (rd_w_q == last_w) ? '0 : rd_w_q + ROW_W'(1);
			remain_q    <= remain_q - VISIT_W'(1);
			first_iss_q <= 1'b0;
		end
		w_s1     <= rd_w_q;
		first_s1 <= first_iss_q;
		last_s1  <= (remain_q == VISIT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue && !found;
		end
	end

	// Allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= N_RESET;
			hint_q        <= FRAME_IDX_W'(RESERVED_FRAMES);
			used_q        <= RES_COUNT;
			clr_q         <= '0;
		end else begin
			if (cfg_we) frame_count_q <= cfg_wdata;
			if (ctl.clear) clr_q <= clr_q + ROW_W'(1);
			if (found) begin
				used_q <= used_q + CNT_W'(1);
				hint_q <= (hit_next < n_eff) ? hit_next[FRAME_IDX_W-1:0] : '0;
			end else if (ctl.free_chk && fbit) begin
				if (used_q != '0) used_q <= used_q - CNT_W'(1);
				if (fidx < hint_q) hint_q <= fidx;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			res_grant_q  <= '0;
			res_status_q <= (cmd_q == CMD_FREE) ? ST_OUT_OF_RANGE : ST_NO_FREE;
		end else if (found) begin
			res_grant_q  <= {hit_idx, {OFFS_W{1'b0}}};
			res_status_q <= ST_ALLOCATED;
		end else if (miss) begin
			res_status_q <= ST_NO_FREE;
		end else if (ctl.free_chk) begin
			res_status_q <= fbit ? ST_FREED : ST_ALREADY_FREE;
		end
	end

	assign free_cnt = (used_q < n_eff) ? (n_eff - used_q) : '0;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) out_data_q <= {free_cnt, res_status_q, res_grant_q};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts            = '0;
		sts.cmd_free   = (cmd_q == CMD_FREE);
		sts.alloc_full = (used_q >= n_eff);
		sts.out_range  = ({{(PIDX_W - CNT_W){1'b0}}, n_eff} <= pidx_q);
		sts.found      = found;
		sts.miss       = miss;
		sts.clear_done = (clr_q == ROW_W'(MAP_WORDS - 1));
		sts.out_free   = out_free;
	end

`ifndef SYNTH
	a_found_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(found && miss))
		else $error("scan reported both a hit and a miss");

	a_alloc_counts: assert property (@(posedge clk) disable iff (!arst_n)
		found |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("allocation did not raise the used count");

	a_alloc_status: assert property (@(posedge clk) disable iff (!arst_n)
		found |=> (res_status_q == ST_ALLOCATED))
		else $error("allocation did not record its status");

	a_free_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.free_chk && fbit && used_q != '0) |=> (used_q == $past(used_q) - CNT_W'(1)))
		else $error("free did not lower the used count");
`endif

endmodule

/* hdl/page_frame_allocator.sv */
// Page frame allocator.
// Requests enter on the s_ stream: s_tuser is the command (0 allocate,
// 1 free) and s_tdata the byte address of the frame to free. Each request
// gives exactly one result on the m_ stream, holding the granted address,
// a status code and the number of free frames left.
// An allocate scans the in-use map from the search hint, one 32-bit map word
// per cycle through a registered read port; a full map answers without a
// scan. A free reads its map word, then checks and clears the frame's bit,
// skipping the check when its address is out of range.
// One request is handled at a time.
// After reset all 128 map words are cleared in one pass, marking the
// reserved frames in use; s_tready stays low until it ends. cfg_we writes
// frame_count, which every stage of a request reads, so it is to be written
// only while no request is in progress; the user is bound to this, as the
// block itself leaves it unenforced. The result sits in an output register;
// the next request is accepted while it waits, and that request's own result waits for m_tready before it loads.
// ============================================================================
// page_frame_allocator: next-fit bitmap page frame allocator, top level
// Connects the sequencer and the map datapath to the stream ports.
// ============================================================================
module page_frame_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pfa_pkg::ADDR_W-1:0]   s_tdata,   // [31:0] frame_address
	input  logic                         s_tuser,   // [0] command
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [23:0] granted_address, [26:24] status, [39:27] free_frame_count
	output logic [pfa_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_we,
	input  logic [pfa_pkg::CNT_W-1:0]    cfg_wdata
);
	import pfa_pkg::*;

	ctl_t ctl;
	sts_t sts;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_cmd    (s_tuser),
		.in_addr   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the page frame allocator
// Allocate and free requests go in on the request stream, from a queue that
// the stimulus process fills. A behavioral copy of the in-use map, the
// next-fit hint and the used-frame count predicts the result of each request
// when it is accepted. The monitor checks every result against those
// predictions, field by field and in order. The run steps through several
// frame counts, saturating values among them, and several patterns of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfa_pkg::*;

	typedef struct {
		logic              cmd;
		logic [ADDR_W-1:0] addr;
	} frame_req_t;

	typedef struct {
		logic [GRANT_W-1:0]  granted;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    free_cnt;
	} frame_res_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [ADDR_W-1:0]   s_tdata   = '0;	// [31:0] frame_address
	logic                s_tuser   = 1'b0;	// [0] command
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	// [23:0] granted_address, [26:24] status, [39:27] free_frame_count
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we    = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata = '0;

	// Behavioral copy of the allocator state.
	bit             frame_busy [MAX_FRAMES];
	int             next_fit_hint;
	int             frames_used;
	logic [CNT_W-1:0] frame_count_reg;

	frame_req_t pending_requests [$];
	frame_res_t expected_results [$];
	int         in_flight;
	int         errors;
	int         requests_sent;
	int         status_seen [5];
	int         send_idle_pct;
	int         recv_stall_pct;

	page_frame_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The register value is clamped to the legal range wherever it is used.
	function automatic int managed_frames();
		int n;
		n = frame_count_reg;
		if (n < N_MIN)
			n = N_MIN;
		if (n > N_MAX)
			n = N_MAX;
		return n;
	endfunction

	function automatic frame_res_t predict_frame_request(frame_req_t r);
		frame_res_t res;
		int n;
		int i;
		int idx;
		n = managed_frames();
		res.granted = '0;
		if (r.cmd == CMD_ALLOC) begin
			res.status = ST_NO_FREE;
			if (frames_used < n) begin
				// A hint left at or above a lowered count restarts the scan at frame 0.
				i = (next_fit_hint < n) ? next_fit_hint : 0;
				for (int c = 0; c < n; c++) begin
					if (!frame_busy[i]) begin
						frame_busy[i] = 1'b1;
						frames_used++;
						next_fit_hint = (i + 1 < n) ? i + 1 : 0;
						res.granted = GRANT_W'(i * FRAME_BYTES);
						res.status = ST_ALLOCATED;
						break;
					end
					i = (i + 1 < n) ? i + 1 : 0;
				end
			end
		end else begin
			idx = int'(r.addr >> OFFS_W);
			if (idx >= n) begin
				res.status = ST_OUT_OF_RANGE;
			end else if (!frame_busy[idx]) begin
				res.status = ST_ALREADY_FREE;
			end else begin
				frame_busy[idx] = 1'b0;
				if (frames_used > 0)
					frames_used--;
				if (idx < next_fit_hint)
					next_fit_hint = idx;
				res.status = ST_FREED;
			end
		end
		res.free_cnt = (frames_used < n) ? CNT_W'(n - frames_used) : '0;
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] frame_addr(int idx);
		return {PIDX_W'(idx), OFFS_W'($urandom)};
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Request driver: predicts each request at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin : request_driver
		frame_req_t head;
		frame_req_t taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken.cmd  = s_tuser;
				taken.addr = s_tdata;
				expected_results.push_back(predict_frame_request(taken));
				requests_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					head = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= head.addr;
					s_tuser  <= head.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		frame_res_t got;
		frame_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.granted  = m_tdata[GRANT_W-1:0];
				got.status   = m_tdata[GRANT_W +: STATUS_W];
				got.free_cnt = m_tdata[GRANT_W+STATUS_W +: CNT_W];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("granted_address", want.granted, got.granted);
					check_field("status", want.status, got.status);
					check_field("free_frame_count", want.free_cnt, got.free_cnt);
					in_flight--;
				end
				if (got.status <= ST_ALREADY_FREE)
					status_seen[got.status]++;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_request(logic cmd, logic [ADDR_W-1:0] addr);
		frame_req_t r;
		r.cmd  = cmd;
		r.addr = addr;
		pending_requests.push_back(r);
		in_flight++;
	endtask

	// Free targets are picked from the live map, so the generator stays only
	// a couple of requests ahead of the driver.
	task automatic queue_random_requests(int count);
		int n;
		int pick;
		int idx;
		int tries;
		logic [ADDR_W-1:0] addr;
		for (int k = 0; k < count; k++) begin
			while (pending_requests.size() >= 2)
				@(posedge clk);
			n = managed_frames();
			pick = $urandom_range(99);
			addr = $urandom;
			if (pick < 45) begin
				queue_request(CMD_ALLOC, addr);
			end else begin
				if (pick < 80) begin
					idx = $urandom_range(n - 1);
					tries = 0;
					while (!frame_busy[idx] && tries < 16) begin
						idx = $urandom_range(n - 1);
						tries++;
					end
					addr = frame_addr(idx);
				end else if (pick < 88) begin
					addr = frame_addr($urandom_range(n - 1));
				end else if (pick < 95) begin
					addr = frame_addr($urandom_range(MAX_FRAMES - 1));
				end
				queue_request(CMD_FREE, addr);
			end
		end
	endtask

	task automatic wait_all_results();
		wait (in_flight == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_count(logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		frame_count_reg = value;
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		for (int k = 0; k < MAX_FRAMES; k++)
			frame_busy[k] = (k < RESERVED_FRAMES);
		next_fit_hint   = RESERVED_FRAMES;
		frames_used     = RESERVED_FRAMES;
		frame_count_reg = N_RESET;
		set_idling(0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset frame count.
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_ALLOC, '1);
		queue_request(CMD_FREE, 32'h0010_1FFF);
		queue_request(CMD_FREE, 32'h0010_1000);
		queue_request(CMD_FREE, 32'hFFFF_FFFF);
		queue_request(CMD_FREE, 32'h0000_0000);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_FREE, 32'h00FF_F000);
		queue_request(CMD_FREE, 32'h0100_0000);
		queue_request(CMD_ALLOC, 32'hA5A5_5A5A);
		queue_request(CMD_FREE, 32'h000F_F123);
		queue_request(CMD_ALLOC, '0);
		wait_all_results();

		// All ones saturates to the largest count.
		write_frame_count('1);
		queue_random_requests(80);
		wait_all_results();

		// Smallest count: the hint and some used frames now lie above it.
		write_frame_count(N_MIN);
		set_idling(71, 0);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_FREE, 32'h0010_0000);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_ALLOC, '0);
		queue_request(CMD_FREE, 32'h0010_1000);
		queue_random_requests(70);
		wait_all_results();

		// Zero saturates to the smallest count.
		write_frame_count('0);
		set_idling(0, 71);
		queue_random_requests(70);
		wait_all_results();

		write_frame_count(CNT_W'($urandom_range(300, 1200)));
		set_idling(33, 33);
		queue_random_requests(40);
		// The sender holds off here until every outstanding result is back.
		wait_all_results();
		queue_random_requests(40);
		wait_all_results();

		write_frame_count(CNT_W'(600));
		set_idling(0, 0);
		queue_random_requests(40);
		wait_all_results();

		write_frame_count(N_MAX);
		set_idling(33, 33);
		queue_random_requests(80);
		wait_all_results();

		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			errors++;
		end
		$display("Checked %0d requests over seven frame-count settings and four idling patterns.",
			requests_sent);
		$display("Statuses seen: allocated %0d, no free frame %0d, freed %0d, out of range %0d, already free %0d",
			status_seen[ST_ALLOCATED], status_seen[ST_NO_FREE], status_seen[ST_FREED],
			status_seen[ST_OUT_OF_RANGE], status_seen[ST_ALREADY_FREE]);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d requests still outstanding", in_flight);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
